/* hdl/i2cmrs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master register sequencer package
// Event and bus command codes, the word size and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmrs_pkg;

  localparam int MAX_WORD_BYTES = 4;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_ACK   = 3'd1,
    OP_NACK  = 3'd2,
    OP_RX    = 3'd3,
    OP_STOP  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_ACK       = 3'd3,
    CMD_NACK_STOP = 3'd4
  } bus_cmd_t;

  function automatic logic [2:0] clamp_count(input logic [2:0] c);
    return (int'(c) > MAX_WORD_BYTES) ? 3'(MAX_WORD_BYTES) : c;
  endfunction

  function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [2:0] idx);
    logic [31:0] sh;
    sh = word >> {idx[1:0], 3'b000};
    return (idx >= 3'd4) ? 8'h00 : sh[7:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/i2c_master_register_sequencer_core.sv */
// ----------------------------------------------------------------------------
// I2C master register sequencer core
// Turns start requests and bus events into bus commands and transmit bytes.
// ----------------------------------------------------------------------------
// Every request is handled as a whole: the state update and the
// result are computed together, and the result is held in an output register
// that is presented in the cycle after acceptance. A new request is taken every
// cycle, including while an earlier result waits, provided that result is
// being taken in the same cycle; the output register is the only stage.
`default_nettype none

module i2c_master_register_sequencer_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [2:0]             in_opcode,
  input  wire logic [6:0]             in_slave_address,
  input  wire logic [31:0]            in_reg_address,
  input  wire logic [2:0]             in_reg_byte_count,
  input  wire logic [2:0]             in_data_byte_count,
  input  wire logic                   in_read_not_write,
  input  wire logic [31:0]            in_write_word,
  input  wire logic [7:0]             in_rx_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_bus_command,
  output logic                        out_tx_valid,
  output logic [7:0]                  out_tx_byte,
  output logic [31:0]                 out_read_word,
  output logic                        out_done_res,
  output logic                        out_busy_res,
  output logic                        out_protocol_error
);
  import i2cmrs_pkg::*;

  typedef enum logic [2:0] {
    PH_INIT       = 3'd0,
    PH_SEND_REG   = 3'd1,
    PH_REQ_READ   = 3'd2,
    PH_READ_DATA  = 3'd3,
    PH_WRITE_DATA = 3'd4,
    PH_SEND_STOP  = 3'd5,
    PH_END        = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        busy_r, busy_nxt;
  logic [6:0]  slv_r, slv_nxt;
  logic [31:0] rega_r, rega_nxt;
  logic [2:0]  regleft_r, regleft_nxt;
  logic [2:0]  dataleft_r, dataleft_nxt;
  logic        dir_r, dir_nxt;
  logic [31:0] word_r, word_nxt;

  logic        out_valid_r, out_valid_nxt;
  bus_cmd_t    cmd_r, cmd_nxt;
  logic        txv_r, txv_nxt;
  logic [7:0]  txb_r, txb_nxt;
  logic        done_r, done_nxt;
  logic        err_r, err_nxt;

  logic        in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    logic [2:0] rdec;
    logic [2:0] ddec;
    phase_nxt    = phase_r;
    busy_nxt     = busy_r;
    slv_nxt      = slv_r;
    rega_nxt     = rega_r;
    regleft_nxt  = regleft_r;
    dataleft_nxt = dataleft_r;
    dir_nxt      = dir_r;
    word_nxt     = word_r;
    cmd_nxt      = CMD_NONE;
    txv_nxt      = 1'b0;
    txb_nxt      = 8'h00;
    done_nxt     = 1'b0;
    err_nxt      = 1'b0;
    rdec         = regleft_r - 3'd1;
    ddec         = dataleft_r - 3'd1;

    case (in_opcode)
      OP_START: begin
        if (busy_r) begin
          err_nxt = 1'b1;
        end else begin
          slv_nxt      = in_slave_address;
          rega_nxt     = in_reg_address;
          regleft_nxt  = clamp_count(in_reg_byte_count);
          dataleft_nxt = clamp_count(in_data_byte_count);
          dir_nxt      = in_read_not_write;
          word_nxt     = in_write_word;
          busy_nxt     = 1'b1;
          phase_nxt    = PH_INIT;
          cmd_nxt      = CMD_START;
          txv_nxt      = 1'b1;
          txb_nxt      = {in_slave_address, 1'b0};
        end
      end
      OP_ACK: begin
        if ((phase_r == PH_INIT && regleft_r == 3'd0) || phase_r == PH_SEND_REG
            || phase_r == PH_WRITE_DATA) begin
          if (dir_r && phase_r != PH_WRITE_DATA) begin
            cmd_nxt   = CMD_START;
            txv_nxt   = 1'b1;
            txb_nxt   = {slv_r, 1'b1};
            phase_nxt = PH_REQ_READ;
          end else if (dataleft_r != 3'd0) begin
            dataleft_nxt = ddec;
            txv_nxt      = 1'b1;
            txb_nxt      = pick_byte(word_r, ddec);
            phase_nxt    = PH_WRITE_DATA;
          end else begin
            cmd_nxt   = CMD_STOP;
            phase_nxt = PH_SEND_STOP;
          end
        end else if (phase_r == PH_INIT) begin
          regleft_nxt = rdec;
          txv_nxt     = 1'b1;
          txb_nxt     = pick_byte(rega_r, rdec);
          if (rdec == 3'd0) begin
            phase_nxt = PH_SEND_REG;
          end
        end else if (phase_r == PH_REQ_READ) begin
          phase_nxt = PH_READ_DATA;
        end else begin
          err_nxt = 1'b1;
        end
      end
      OP_NACK: begin
        if (phase_r == PH_REQ_READ) begin
          cmd_nxt = CMD_START;
          txv_nxt = 1'b1;
          txb_nxt = {slv_r, 1'b1};
        end else begin
          err_nxt = 1'b1;
        end
      end
      OP_RX: begin
        if (phase_r != PH_READ_DATA) begin
          err_nxt = 1'b1;
        end else if (dataleft_r != 3'd0 && ddec != 3'd0) begin
          word_nxt     = {word_r[23:0], in_rx_byte};
          dataleft_nxt = ddec;
          cmd_nxt      = CMD_ACK;
        end else begin
          if (dataleft_r != 3'd0) begin
            word_nxt     = {word_r[23:0], in_rx_byte};
            dataleft_nxt = ddec;
          end
          cmd_nxt   = CMD_NACK_STOP;
          phase_nxt = PH_SEND_STOP;
        end
      end
      OP_STOP: begin
        if (phase_r == PH_SEND_STOP) begin
          phase_nxt = PH_END;
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_END;
      busy_r      <= 1'b0;
      slv_r       <= '0;
      rega_r      <= '0;
      regleft_r   <= '0;
      dataleft_r  <= '0;
      dir_r       <= 1'b0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r    <= phase_nxt;
        busy_r     <= busy_nxt;
        slv_r      <= slv_nxt;
        rega_r     <= rega_nxt;
        regleft_r  <= regleft_nxt;
        dataleft_r <= dataleft_nxt;
        dir_r      <= dir_nxt;
        word_r     <= word_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= cmd_nxt;
      txv_r  <= txv_nxt;
      txb_r  <= txb_nxt;
      done_r <= done_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_command    = cmd_r;
  assign out_tx_valid       = txv_r;
  assign out_tx_byte        = txb_r;
  assign out_read_word      = word_r;
  assign out_done_res       = done_r;
  assign out_busy_res       = busy_r;
  assign out_protocol_error = err_r;

  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> phase_r == PH_END)
    else $error("idle sequencer is not at end of transaction");

  a_regleft_init: assert property (@(posedge clk) disable iff (!rst_n)
    (regleft_r != 3'd0) |-> phase_r == PH_INIT)
    else $error("register bytes pending outside the initial phase");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (!busy_r && !err_r))
    else $error("done reported while still busy or in error");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> (cmd_r == CMD_NONE && !txv_r && !done_r))
    else $error("rejected request produced bus activity");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !txv_r) |-> txb_r == 8'h00)
    else $error("transmit byte not cleared without a transmit");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// I2C master register sequencer testbench
// Sends start requests and bus events to the sequencer core, with random
// gaps on the request side and random stalls on the result side. A
// behavioural model of the transaction phases predicts every result, and
// each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmrs_pkg::*;

  localparam logic [2:0] OP_UNDEFINED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_TARGET = 370;
  localparam int FINAL_TARGET = 440;
  localparam int PRINT_LIMIT = 40;

  typedef enum logic [2:0] {
    SEQ_ADDR, SEQ_REG_SENT, SEQ_RESTART, SEQ_READ, SEQ_WRITE, SEQ_STOP, SEQ_IDLE
  } seq_phase_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  slave_address;
    logic [31:0] reg_address;
    logic [2:0]  reg_byte_count;
    logic [2:0]  data_byte_count;
    logic        read_not_write;
    logic [31:0] write_word;
    logic [7:0]  rx_byte;
  } bus_request_t;

  typedef struct packed {
    bus_cmd_t    cmd;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [31:0] read_word;
    logic        done;
    logic        busy;
    logic        error;
  } bus_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [6:0]  in_slave_address = '0;
  logic [31:0] in_reg_address = '0;
  logic [2:0]  in_reg_byte_count = '0;
  logic [2:0]  in_data_byte_count = '0;
  logic        in_read_not_write = 1'b0;
  logic [31:0] in_write_word = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_bus_command;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic [31:0] out_read_word;
  logic        out_done_res;
  logic        out_busy_res;
  logic        out_protocol_error;

  seq_phase_t  seq_phase = SEQ_IDLE;
  logic        seq_busy = 1'b0;
  logic [6:0]  held_slave = '0;
  logic [31:0] held_reg = '0;
  logic [2:0]  reg_left = '0;
  logic [2:0]  data_left = '0;
  logic        read_dir = 1'b0;
  logic [31:0] data_word = '0;

  bus_result_t expected_results[$];
  bit          gaps_on = 1'b0;
  int          mismatch_count = 0;
  int          checked_count = 0;
  int          request_count = 0;
  int          useful_count = 0;
  int          completed_count = 0;
  int          cycle_count = 0;
  int          stall_run = 0;
  bit          stalling;

  i2c_master_register_sequencer_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!gaps_on) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stalling = ($urandom_range(0, 2) == 0);
      stall_run = stalling ? $urandom_range(1, 15) : $urandom_range(1, 20);
      out_stall <= stalling;
    end
  end

  // ---- prediction ----

  function automatic logic [2:0] limit_count(input logic [2:0] c);
    return (c > MAX_WORD_BYTES) ? 3'(MAX_WORD_BYTES) : c;
  endfunction

  function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [2:0] idx);
    return (idx > 3'd3) ? 8'h00 : w[idx * 8 +: 8];
  endfunction

  function automatic void put_byte(inout bus_result_t r, input logic [7:0] b);
    r.tx_valid = 1'b1;
    r.tx_byte = b;
  endfunction

  function automatic void issue_read_restart(inout bus_result_t r);
    r.cmd = CMD_START;
    put_byte(r, {held_slave, 1'b1});
    seq_phase = SEQ_RESTART;
  endfunction

  function automatic void next_write_byte(inout bus_result_t r);
    if (data_left != 0) begin
      data_left--;
      put_byte(r, byte_of(data_word, data_left));
      seq_phase = SEQ_WRITE;
    end else begin
      r.cmd = CMD_STOP;
      seq_phase = SEQ_STOP;
    end
  endfunction

  function automatic void finish_register(inout bus_result_t r);
    if (read_dir)
      issue_read_restart(r);
    else
      next_write_byte(r);
  endfunction

  function automatic bus_result_t sequence_bus_event(input bus_request_t rq);
    bus_result_t r;
    r = '0;
    r.cmd = CMD_NONE;
    case (rq.opcode)
      OP_START: begin
        if (seq_busy) begin
          r.error = 1'b1;
        end else begin
          held_slave = rq.slave_address;
          held_reg = rq.reg_address;
          reg_left = limit_count(rq.reg_byte_count);
          data_left = limit_count(rq.data_byte_count);
          read_dir = rq.read_not_write;
          data_word = rq.write_word;
          seq_busy = 1'b1;
          seq_phase = SEQ_ADDR;
          r.cmd = CMD_START;
          put_byte(r, {held_slave, 1'b0});
        end
      end
      OP_ACK: begin
        case (seq_phase)
          SEQ_ADDR: begin
            if (reg_left != 0) begin
              reg_left--;
              put_byte(r, byte_of(held_reg, reg_left));
              if (reg_left == 0)
                seq_phase = SEQ_REG_SENT;
            end else begin
              finish_register(r);
            end
          end
          SEQ_REG_SENT: finish_register(r);
          SEQ_RESTART: seq_phase = SEQ_READ;
          SEQ_WRITE: next_write_byte(r);
          default: r.error = 1'b1;
        endcase
      end
      OP_NACK: begin
        if (seq_phase == SEQ_RESTART)
          issue_read_restart(r);
        else
          r.error = 1'b1;
      end
      OP_RX: begin
        if (seq_phase != SEQ_READ) begin
          r.error = 1'b1;
        end else if (data_left > 1) begin
          data_word = {data_word[23:0], rq.rx_byte};
          data_left--;
          r.cmd = CMD_ACK;
        end else begin
          // A byte arriving with nothing left to read is dropped.
          if (data_left == 1) begin
            data_word = {data_word[23:0], rq.rx_byte};
            data_left--;
          end
          r.cmd = CMD_NACK_STOP;
          seq_phase = SEQ_STOP;
        end
      end
      OP_STOP: begin
        if (seq_phase == SEQ_STOP) begin
          seq_phase = SEQ_IDLE;
          seq_busy = 1'b0;
          r.done = 1'b1;
        end else begin
          r.error = 1'b1;
        end
      end
      default: r.error = 1'b1;
    endcase
    r.read_word = data_word;
    r.busy = seq_busy;
    return r;
  endfunction

  // ---- checking ----

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("ERROR at %0t ns, result %0d: %s", $time, checked_count, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    bus_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("bus_command", 32'(out_bus_command), 32'(want.cmd));
        check_field("tx_valid", 32'(out_tx_valid), 32'(want.tx_valid));
        check_field("tx_byte", 32'(out_tx_byte), 32'(want.tx_byte));
        check_field("read_word", out_read_word, want.read_word);
        check_field("done", 32'(out_done_res), 32'(want.done));
        check_field("busy", 32'(out_busy_res), 32'(want.busy));
        check_field("protocol_error", 32'(out_protocol_error), 32'(want.error));
      end
      checked_count++;
    end
  end

  // ---- stimulus ----

  task automatic send_request(input bus_request_t rq);
    bus_result_t want;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= rq.opcode;
    in_slave_address <= rq.slave_address;
    in_reg_address <= rq.reg_address;
    in_reg_byte_count <= rq.reg_byte_count;
    in_data_byte_count <= rq.data_byte_count;
    in_read_not_write <= rq.read_not_write;
    in_write_word <= rq.write_word;
    in_rx_byte <= rq.rx_byte;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = sequence_bus_event(rq);
    expected_results.push_back(want);
    request_count++;
    if (!want.error)
      useful_count++;
    if (want.done)
      completed_count++;
  endtask

  function automatic bus_request_t random_request(input logic [2:0] op);
    bus_request_t rq;
    rq.opcode = op;
    rq.slave_address = 7'($urandom());
    rq.reg_address = $urandom();
    rq.reg_byte_count = 3'($urandom());
    rq.data_byte_count = 3'($urandom());
    rq.read_not_write = 1'($urandom());
    rq.write_word = $urandom();
    rq.rx_byte = 8'($urandom());
    return rq;
  endfunction

  task automatic send_event(input logic [2:0] op, input logic [7:0] rx);
    bus_request_t rq;
    rq = random_request(op);
    rq.rx_byte = rx;
    send_request(rq);
  endtask

  task automatic send_start(input logic [6:0] slave, input logic [31:0] reg_addr,
                            input logic [2:0] reg_count, input logic [2:0] data_count,
                            input logic rd, input logic [31:0] word);
    bus_request_t rq;
    rq = random_request(OP_START);
    rq.slave_address = slave;
    rq.reg_address = reg_addr;
    rq.reg_byte_count = reg_count;
    rq.data_byte_count = data_count;
    rq.read_not_write = rd;
    rq.write_word = word;
    send_request(rq);
  endtask

  // One transaction driven to its end, with stray events mixed in.
  task automatic run_sequence();
    bus_request_t rq;
    if ($urandom_range(0, 5) == 0)
      send_request(random_request(3'($urandom())));
    if (!seq_busy) begin
      rq = random_request(OP_START);
      rq.reg_byte_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
      rq.data_byte_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
      send_request(rq);
    end
    while (seq_busy) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(random_request(3'($urandom())));
      end else begin
        case (seq_phase)
          SEQ_RESTART: send_event(($urandom_range(0, 3) == 0) ? OP_NACK : OP_ACK,
                                  8'($urandom()));
          SEQ_READ: send_event(OP_RX, 8'($urandom()));
          SEQ_STOP: send_event(OP_STOP, 8'($urandom()));
          default: send_event(OP_ACK, 8'($urandom()));
        endcase
      end
    end
  endtask

  task automatic test_idle_events();
    send_event(OP_ACK, 8'hFF);
    send_event(OP_UNDEFINED, 8'h00);
  endtask

  task automatic test_write_long_register();
    send_start(7'h7F, 32'hFFFF_FFFF, 3'd7, 3'd0, 1'b0, 32'hFFFF_FFFF);
    send_start(7'h00, 32'h0000_0000, 3'd0, 3'd0, 1'b1, 32'h0000_0000);
    repeat (MAX_WORD_BYTES) send_event(OP_ACK, 8'h00);
    send_event(OP_NACK, 8'hFF);
    send_event(OP_ACK, 8'h00);
    send_event(OP_STOP, 8'h00);
  endtask

  task automatic test_read_with_retries();
    send_start(7'h00, 32'h0000_0000, 3'd0, 3'd5, 1'b1, 32'h0000_0000);
    send_event(OP_ACK, 8'h00);
    send_event(OP_NACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_RX, 8'hFF);
    send_event(OP_STOP, 8'h00);
    send_event(OP_RX, 8'h00);
    send_event(OP_RX, 8'h5A);
    send_event(OP_RX, 8'hC3);
    send_event(OP_STOP, 8'h00);
  endtask

  task automatic test_read_empty();
    send_start(7'h55, 32'h1234_5678, 3'd1, 3'd0, 1'b1, 32'hFFFF_FFFF);
    send_event(OP_ACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_RX, 8'hA5);
    send_event(OP_STOP, 8'h00);
  endtask

  task automatic test_random_traffic();
    while (useful_count < RANDOM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      run_sequence();
    end
  endtask

  task automatic test_final_burst();
    gaps_on = 1'b0;
    while (useful_count < FINAL_TARGET)
      run_sequence();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;
    test_idle_events();
    test_write_long_register();
    test_read_with_retries();
    test_read_empty();
    test_random_traffic();
    test_final_burst();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d requests, %0d of them accepted as valid bus events.",
             request_count, useful_count);
    $display("Checked %0d results; %0d transactions ran to completion.",
             checked_count, completed_count);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
